>>> rtl/core/box_primitive_overlap_classifier_macros.svh
// Assertion helpers for the box overlap classifier.
`ifndef BOX_PRIMITIVE_OVERLAP_CLASSIFIER_MACROS_SVH
`define BOX_PRIMITIVE_OVERLAP_CLASSIFIER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define BPOC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define BPOC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bpoc_pkg.sv
// ----------------------------------------------------------------------------
// bpoc_pkg
// Widths, codes and stage payload types of the box overlap classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package bpoc_pkg;

  localparam int CW  = 32;        // coordinate width
  localparam int SW  = CW - 1;    // size width
  localparam int DW  = CW;        // magnitude of a clamped distance
  localparam int SQW = 2 * DW;    // one squared distance
  localparam int PW  = 2 * SW;    // product of two sizes
  localparam int XW  = SQW + 1;   // dx^2 + dy^2
  localparam int SPW = SQW + 2;   // dx^2 + dy^2 + dz^2
  localparam int LW  = 128;       // cone compare width
  localparam int CFG_IW = 3;
  localparam int IN_TW  = 6 * CW;
  localparam int OUT_TW = 8;

  localparam logic [1:0] SHAPE_SPHERE   = 2'd0;
  localparam logic [1:0] SHAPE_BOX      = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd2;
  localparam logic [1:0] SHAPE_CONE     = 2'd3;

  localparam logic [CFG_IW-1:0] REG_SHAPE_KIND = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CENTER_X   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CENTER_Y   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CENTER_Z   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SIZE_A     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SIZE_B     = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SIZE_C     = 3'd6;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } adv_t;

  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
    logic [SW-1:0]        sa;
    logic [SW-1:0]        sb;
    logic [SW-1:0]        sc;
  } prim_t;

  typedef struct packed {
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [DW-1:0] dz;
    logic [SW-1:0] k;
    logic          span_ok;
    logic          zin;
  } s1_t;

  typedef struct packed {
    logic [XW-1:0]  dxy;
    logic [SPW-1:0] dsph;
    logic [PW-1:0]  rr;
    logic [PW-1:0]  hh;
    logic [PW-1:0]  rk;
    logic           span_ok;
    logic           zin;
  } s3_t;

  typedef struct packed {
    logic [LW-1:0] lhs;
    logic [LW-1:0] rhs;
    logic          sph_ok;
    logic          cyl_ok;
    logic          span_ok;
    logic          zin;
  } s5_t;

endpackage
`default_nettype wire

>>> rtl/core/box_primitive_overlap_classifier.sv
// ----------------------------------------------------------------------------
// box_primitive_overlap_classifier
// Axis-aligned box versus sphere, box, z-cylinder or z-cone overlap test.
// ----------------------------------------------------------------------------
// One box transfer in gives one hit transfer out, in order. The block takes
// a new box every cycle while out_tready does not hold the pipe; each box is
// registered in turn through clamp, squares, sums, partial products, wide sums
// and the final compare in the output register. Every stage holds on its own
// when the next one is full, so back-pressure on out_tready stalls only as far
// as it must and nothing is dropped or repeated. The cone test compares 128-bit
// products built from partial products of the split operands, which sets the
// pipeline depth. Write the primitive registers only while no box is in flight.
// ----------------------------------------------------------------------------
`default_nettype none
module box_primitive_overlap_classifier (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [bpoc_pkg::CFG_IW-1:0]      cfg_index,
  input  wire logic [bpoc_pkg::CW-1:0]          cfg_wdata,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
  input  wire logic [bpoc_pkg::IN_TW-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // hit, then zero fill
  output logic [bpoc_pkg::OUT_TW-1:0]           out_tdata
);

  // Primitive registers
  logic [1:0]      shape_kind_r;
  bpoc_pkg::prim_t prim_r;

  // Stage valids and advance enables
  logic [4:0]      vld_r;
  logic [4:0]      vld_nxt;
  bpoc_pkg::adv_t  adv;
  logic            adv_out;
  logic            out_tvalid_nxt;
  logic            hit_nxt;

  bpoc_pkg::s1_t   s1_r;
  bpoc_pkg::s3_t   s3_r;
  bpoc_pkg::s5_t   s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_kind_r <= bpoc_pkg::SHAPE_SPHERE;
      prim_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bpoc_pkg::REG_SHAPE_KIND: shape_kind_r <= cfg_wdata[1:0];
        bpoc_pkg::REG_CENTER_X:   prim_r.cx    <= cfg_wdata;
        bpoc_pkg::REG_CENTER_Y:   prim_r.cy    <= cfg_wdata;
        bpoc_pkg::REG_CENTER_Z:   prim_r.cz    <= cfg_wdata;
        bpoc_pkg::REG_SIZE_A:     prim_r.sa    <= cfg_wdata[bpoc_pkg::SW-1:0];
        bpoc_pkg::REG_SIZE_B:     prim_r.sb    <= cfg_wdata[bpoc_pkg::SW-1:0];
        bpoc_pkg::REG_SIZE_C:     prim_r.sc    <= cfg_wdata[bpoc_pkg::SW-1:0];
        default: ;
      endcase
    end
  end

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    adv_out   = !out_tvalid || out_tready;
    adv.s5    = !vld_r[4] || adv_out;
    adv.s4    = !vld_r[3] || adv.s5;
    adv.s3    = !vld_r[2] || adv.s4;
    adv.s2    = !vld_r[1] || adv.s3;
    adv.s1    = !vld_r[0] || adv.s2;
    in_tready = adv.s1;

    vld_nxt[0] = adv.s1 ? in_tvalid : vld_r[0];
    vld_nxt[1] = adv.s2 ? vld_r[0]  : vld_r[1];
    vld_nxt[2] = adv.s3 ? vld_r[1]  : vld_r[2];
    vld_nxt[3] = adv.s4 ? vld_r[2]  : vld_r[3];
    vld_nxt[4] = adv.s5 ? vld_r[3]  : vld_r[4];
    out_tvalid_nxt = adv_out ? vld_r[4] : out_tvalid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      out_tvalid <= 1'b0;
    end else begin
      vld_r      <= vld_nxt;
      out_tvalid <= out_tvalid_nxt;
    end
  end

  bpoc_front u_front (
    .clk  (clk),
    .adv  (adv),
    .prim (prim_r),
    .x0   (in_tdata[0*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .y0   (in_tdata[1*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .z0   (in_tdata[2*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .x1   (in_tdata[3*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .y1   (in_tdata[4*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .z1   (in_tdata[5*bpoc_pkg::CW +: bpoc_pkg::CW]),
    .s1_r (s1_r)
  );

  bpoc_square u_square (
    .clk  (clk),
    .adv  (adv),
    .prim (prim_r),
    .s1_r (s1_r),
    .s3_r (s3_r)
  );

  bpoc_wide u_wide (
    .clk  (clk),
    .adv  (adv),
    .s3_r (s3_r),
    .s5_r (s5_r)
  );

  // Final pick by shape; a flat cone never hits.
  always_comb begin
    case (shape_kind_r)
      bpoc_pkg::SHAPE_SPHERE:   hit_nxt = s5_r.sph_ok;
      bpoc_pkg::SHAPE_BOX:      hit_nxt = s5_r.span_ok;
      bpoc_pkg::SHAPE_CYLINDER: hit_nxt = s5_r.zin && s5_r.cyl_ok;
      bpoc_pkg::SHAPE_CONE:     hit_nxt = (prim_r.sb != '0) && s5_r.zin &&
                                          (s5_r.lhs <= s5_r.rhs);
      default:                  hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_tdata <= {{(bpoc_pkg::OUT_TW-1){1'b0}}, hit_nxt};
    end
  end

`include "box_primitive_overlap_classifier_macros.svh"

  // An empty output register must leave the whole pipe open.
  `BPOC_ASSERT_NOW(a_empty_accepts, !out_tvalid, in_tready, "empty pipe refused input")
  // Output valid only rises from a full last stage.
  `BPOC_ASSERT_NOW(a_out_from_s5, $rose(out_tvalid), $past(vld_r[4]), "output from nowhere")
  // Padding above the hit bit stays zero.
  `BPOC_ASSERT_NOW(a_pad_zero, out_tvalid, out_tdata[bpoc_pkg::OUT_TW-1:1] == '0,
                   "tdata padding not zero")

endmodule
`default_nettype wire

>>> rtl/core/bpoc_front.sv
// ----------------------------------------------------------------------------
// bpoc_front
// Stage 1: clamp to the box, distance magnitudes, span and height tests.
// ----------------------------------------------------------------------------
`default_nettype none
module bpoc_front (
  input  wire logic                          clk,
  input  wire bpoc_pkg::adv_t                adv,
  input  wire bpoc_pkg::prim_t               prim,
  input  wire logic signed [bpoc_pkg::CW-1:0] x0,
  input  wire logic signed [bpoc_pkg::CW-1:0] y0,
  input  wire logic signed [bpoc_pkg::CW-1:0] z0,
  input  wire logic signed [bpoc_pkg::CW-1:0] x1,
  input  wire logic signed [bpoc_pkg::CW-1:0] y1,
  input  wire logic signed [bpoc_pkg::CW-1:0] z1,
  output bpoc_pkg::s1_t                      s1_r
);

  function automatic logic [bpoc_pkg::DW-1:0] axis_dist(
    input logic signed [bpoc_pkg::CW-1:0] lo,
    input logic signed [bpoc_pkg::CW-1:0] hi,
    input logic signed [bpoc_pkg::CW-1:0] c
  );
    logic signed [bpoc_pkg::CW-1:0] cl;
    logic signed [bpoc_pkg::CW:0]   diff;
    logic signed [bpoc_pkg::CW:0]   mag;
    cl   = (c < hi) ? c : hi;
    cl   = (lo > cl) ? lo : cl;
    diff = $signed({cl[bpoc_pkg::CW-1], cl}) - $signed({c[bpoc_pkg::CW-1], c});
    mag  = diff[bpoc_pkg::CW] ? -diff : diff;
    return mag[bpoc_pkg::DW-1:0];
  endfunction

  function automatic logic span_ok(
    input logic signed [bpoc_pkg::CW-1:0] lo,
    input logic signed [bpoc_pkg::CW-1:0] hi,
    input logic signed [bpoc_pkg::CW-1:0] c,
    input logic [bpoc_pkg::SW-1:0]        w
  );
    logic signed [bpoc_pkg::CW+1:0] l2;
    logic signed [bpoc_pkg::CW+1:0] h2;
    logic signed [bpoc_pkg::CW+1:0] c2;
    logic signed [bpoc_pkg::CW+1:0] wx;
    l2 = $signed({lo[bpoc_pkg::CW-1], lo, 1'b0});
    h2 = $signed({hi[bpoc_pkg::CW-1], hi, 1'b0});
    c2 = $signed({c[bpoc_pkg::CW-1], c, 1'b0});
    wx = $signed({3'b000, w});
    return (l2 <= c2 + wx) && (h2 >= c2 - wx);
  endfunction

  logic signed [bpoc_pkg::CW:0]   top_z;
  logic signed [bpoc_pkg::CW-1:0] zl;
  logic signed [bpoc_pkg::CW:0]   dzl;
  logic signed [bpoc_pkg::CW+1:0] kk;
  bpoc_pkg::s1_t                  s1_nxt;

  always_comb begin
    top_z  = $signed({prim.cz[bpoc_pkg::CW-1], prim.cz}) + $signed({2'b00, prim.sb});
    zl     = (z0 > prim.cz) ? z0 : prim.cz;
    dzl    = $signed({zl[bpoc_pkg::CW-1], zl}) -
             $signed({prim.cz[bpoc_pkg::CW-1], prim.cz});
    kk     = $signed({3'b000, prim.sb}) - $signed({dzl[bpoc_pkg::CW], dzl});
    s1_nxt.dx = axis_dist(x0, x1, prim.cx);
    s1_nxt.dy = axis_dist(y0, y1, prim.cy);
    s1_nxt.dz = axis_dist(z0, z1, prim.cz);
    s1_nxt.k  = kk[bpoc_pkg::CW+1] ? '0 : kk[bpoc_pkg::SW-1:0];
    s1_nxt.span_ok = span_ok(x0, x1, prim.cx, prim.sa) &&
                     span_ok(y0, y1, prim.cy, prim.sb) &&
                     span_ok(z0, z1, prim.cz, prim.sc);
    s1_nxt.zin = ($signed({z0[bpoc_pkg::CW-1], z0}) <= top_z) && (z1 >= prim.cz);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bpoc_square.sv
// ----------------------------------------------------------------------------
// bpoc_square
// Stages 2 and 3: squares and size products, then distance sums.
// ----------------------------------------------------------------------------
`default_nettype none
module bpoc_square (
  input  wire logic            clk,
  input  wire bpoc_pkg::adv_t  adv,
  input  wire bpoc_pkg::prim_t prim,
  input  wire bpoc_pkg::s1_t   s1_r,
  output bpoc_pkg::s3_t        s3_r
);

  logic [bpoc_pkg::SQW-1:0] dx2_r, dy2_r, dz2_r;
  logic [bpoc_pkg::PW-1:0]  rr_r, hh_r, rk_r;
  logic                     span2_r, zin2_r;
  bpoc_pkg::s3_t            s3_nxt;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      dx2_r   <= s1_r.dx * s1_r.dx;
      dy2_r   <= s1_r.dy * s1_r.dy;
      dz2_r   <= s1_r.dz * s1_r.dz;
      rr_r    <= prim.sa * prim.sa;
      hh_r    <= prim.sb * prim.sb;
      rk_r    <= prim.sa * s1_r.k;
      span2_r <= s1_r.span_ok;
      zin2_r  <= s1_r.zin;
    end
  end

  always_comb begin
    s3_nxt.dxy  = {1'b0, dx2_r} + {1'b0, dy2_r};
    s3_nxt.dsph = {2'b00, dx2_r} + {2'b00, dy2_r} + {2'b00, dz2_r};
    s3_nxt.rr   = rr_r;
    s3_nxt.hh   = hh_r;
    s3_nxt.rk   = rk_r;
    s3_nxt.span_ok = span2_r;
    s3_nxt.zin  = zin2_r;
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_r <= s3_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/bpoc_wide.sv
// ----------------------------------------------------------------------------
// bpoc_wide
// Stages 4 and 5: cone partial products and the sphere and cylinder compares, then the cone sums.
// ----------------------------------------------------------------------------
`default_nettype none
module bpoc_wide (
  input  wire logic           clk,
  input  wire bpoc_pkg::adv_t adv,
  input  wire bpoc_pkg::s3_t  s3_r,
  output bpoc_pkg::s5_t       s5_r
);

  logic [63:0] p00_r;
  logic [61:0] p01_r;
  logic [64:0] p10_r;
  logic [62:0] p11_r;
  logic [63:0] q00_r;
  logic [61:0] q01_r;
  logic [59:0] q11_r;
  logic        sph4_r, cyl4_r, span4_r, zin4_r;
  bpoc_pkg::s5_t s5_nxt;

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      p00_r   <= s3_r.dxy[31:0]  * s3_r.hh[31:0];
      p01_r   <= s3_r.dxy[31:0]  * s3_r.hh[61:32];
      p10_r   <= s3_r.dxy[64:32] * s3_r.hh[31:0];
      p11_r   <= s3_r.dxy[64:32] * s3_r.hh[61:32];
      q00_r   <= s3_r.rk[31:0]   * s3_r.rk[31:0];
      q01_r   <= s3_r.rk[31:0]   * s3_r.rk[61:32];
      q11_r   <= s3_r.rk[61:32]  * s3_r.rk[61:32];
      sph4_r  <= s3_r.dsph <= {4'h0, s3_r.rr};
      cyl4_r  <= s3_r.dxy  <= {3'h0, s3_r.rr};
      span4_r <= s3_r.span_ok;
      zin4_r  <= s3_r.zin;
    end
  end

  always_comb begin
    s5_nxt.lhs = {64'd0, p00_r} + {34'd0, p01_r, 32'd0} + {31'd0, p10_r, 32'd0} +
                 {1'b0, p11_r, 64'd0};
    s5_nxt.rhs = {64'd0, q00_r} + {33'd0, q01_r, 33'd0} + {4'd0, q11_r, 64'd0};
    s5_nxt.sph_ok  = sph4_r;
    s5_nxt.cyl_ok  = cyl4_r;
    s5_nxt.span_ok = span4_r;
    s5_nxt.zin     = zin4_r;
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      s5_r <= s5_nxt;
    end
  end

endmodule
`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for the box overlap classifier: a sphere, box, cylinder or cone is
// set through the register port, boxes stream in with bursts and gaps, and
// every hit flag is checked in order against a predictor computed here.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bpoc_pkg::*;

  localparam int LATENCY = 6;

  typedef struct {
    logic signed [CW-1:0] x0, y0, z0, x1, y1, z1;
  } box_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;

  // Primitive as the bench sees it.
  logic [1:0] pr_kind;
  logic signed [CW-1:0] pr_cx, pr_cy, pr_cz;
  logic [SW-1:0] pr_sa, pr_sb, pr_sc;

  box_t pending_boxes[$];
  logic [OUT_TW-1:0] expected_hits[$];
  int mismatches = 0;
  int hits_seen = 0;
  int checked = 0;
  int sent = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off = 0;
  bit stall_mode = 1'b0;

  box_primitive_overlap_classifier DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Distance from c to the closest point of [lo,hi], squared, exact.
  function automatic logic [127:0] axis_sq(logic signed [CW-1:0] lo,
                                           logic signed [CW-1:0] hi,
                                           logic signed [CW-1:0] c);
    logic signed [CW:0] p;
    logic signed [CW+1:0] d;
    logic [127:0] m;
    p = (c < hi) ? c : hi;
    if (lo > p) p = lo;
    d = p - c;
    m = (d < 0) ? -d : d;
    return m * m;
  endfunction

  function automatic bit span_ok(logic signed [CW-1:0] lo, logic signed [CW-1:0] hi,
                                 logic signed [CW-1:0] c, logic [SW-1:0] w);
    logic signed [63:0] l2, h2, c2, ww;
    l2 = 64'(lo) * 2;
    h2 = 64'(hi) * 2;
    c2 = 64'(c) * 2;
    ww = {33'd0, w};
    return (l2 <= c2 + ww) && (h2 >= c2 - ww);
  endfunction

  function automatic logic [OUT_TW-1:0] overlap_hit(box_t b);
    logic [255:0] rr, dxy, lhs, rhs, rk;
    logic signed [63:0] zl, k, top;
    bit zin, hit;
    rr = 256'(pr_sa) * 256'(pr_sa);
    dxy = 256'(axis_sq(b.x0, b.x1, pr_cx)) + 256'(axis_sq(b.y0, b.y1, pr_cy));
    top = 64'(pr_cz) + 64'({33'd0, pr_sb});
    zin = (64'(b.z0) <= top) && (b.z1 >= pr_cz);
    hit = 1'b0;
    case (pr_kind)
      SHAPE_SPHERE: hit = (dxy + 256'(axis_sq(b.z0, b.z1, pr_cz))) <= rr;
      SHAPE_BOX: hit = span_ok(b.x0, b.x1, pr_cx, pr_sa) &&
                       span_ok(b.y0, b.y1, pr_cy, pr_sb) &&
                       span_ok(b.z0, b.z1, pr_cz, pr_sc);
      SHAPE_CYLINDER: hit = zin && (dxy <= rr);
      default: begin
        zl = (b.z0 > pr_cz) ? 64'(b.z0) : 64'(pr_cz);
        k = 64'({33'd0, pr_sb}) - (zl - 64'(pr_cz));
        if (k < 0) k = 0;
        rk = 256'(pr_sa) * 256'(k);
        lhs = dxy * (256'(pr_sb) * 256'(pr_sb));
        rhs = rk * rk;
        if (pr_sb != 0 && zin) hit = lhs <= rhs;
      end
    endcase
    return {7'd0, hit};
  endfunction

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SHAPE_KIND: pr_kind = val[1:0];
      REG_CENTER_X: pr_cx = val;
      REG_CENTER_Y: pr_cy = val;
      REG_CENTER_Z: pr_cz = val;
      REG_SIZE_A: pr_sa = val[SW-1:0];
      REG_SIZE_B: pr_sb = val[SW-1:0];
      default: pr_sc = val[SW-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_primitive(logic [1:0] kind, logic [CW-1:0] cx, logic [CW-1:0] cy,
                               logic [CW-1:0] cz, logic [CW-1:0] a, logic [CW-1:0] b,
                               logic [CW-1:0] c);
    write_reg(REG_SHAPE_KIND, {30'd0, kind});
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_SIZE_A, a);
    write_reg(REG_SIZE_B, b);
    write_reg(REG_SIZE_C, c);
  endtask

  // Wait until the queue is drained and nothing is in flight.
  task automatic drain;
    int guard;
    guard = 0;
    while ((pending_boxes.size() != 0 || in_tvalid || expected_hits.size() != 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] near_coord(logic signed [CW-1:0] c, int span);
    return c + $signed(32'($urandom_range(0, 2 * span))) - span;
  endfunction

  // Box around the primitive, so hits and misses are both common.
  task automatic push_near_box(int span);
    box_t b;
    b.x0 = near_coord(pr_cx, span);
    b.y0 = near_coord(pr_cy, span);
    b.z0 = near_coord(pr_cz, span);
    b.x1 = b.x0 + $signed(32'($urandom_range(0, span)));
    b.y1 = b.y0 + $signed(32'($urandom_range(0, span)));
    b.z1 = b.z0 + $signed(32'($urandom_range(0, span)));
    if ($urandom_range(0, 19) == 0) begin
      // inverted box, applied as given
      b.x0 = b.x1 + 1;
    end
    pending_boxes = {pending_boxes, b};
  endtask

  task automatic push_raw_box;
    box_t b;
    b.x0 = $urandom; b.y0 = $urandom; b.z0 = $urandom;
    b.x1 = $urandom; b.y1 = $urandom; b.z1 = $urandom;
    pending_boxes = {pending_boxes, b};
  endtask

  task automatic push_box(int x0, int y0, int z0, int x1, int y1, int z1);
    box_t b;
    b.x0 = x0; b.y0 = y0; b.z0 = z0; b.x1 = x1; b.y1 = y1; b.z1 = z1;
    pending_boxes = {pending_boxes, b};
  endtask

  // Driver: bursts of random length with random gaps in between.
  always @(posedge clk) begin
    box_t b;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        b = pending_boxes.pop_front();
        expected_hits = {expected_hits, overlap_hit(b)};
        sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered box until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_boxes.size() != 0) begin
        b = pending_boxes[0];
        in_tvalid <= 1'b1;
        in_tdata <= {b.z1, b.y1, b.x1, b.z0, b.y0, b.x0};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: own stall pattern, with an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode = ~stall_mode;
      out_tready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Monitor: compare each hit transfer with the oldest expectation.
  always @(posedge clk) begin
    logic [OUT_TW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_hits.pop_front();
        checked++;
        if (out_tdata[0]) hits_seen++;
        if (out_tdata !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at result %0d: expected %h got %h", checked, want, out_tdata);
        end
      end
    end
  end

  initial begin
    int phase;
    pr_kind = SHAPE_SPHERE;
    pr_cx = 0; pr_cy = 0; pr_cz = 0; pr_sa = 0; pr_sb = 0; pr_sc = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset primitive is a point sphere at the origin.
    push_box(0, 0, 0, 0, 0, 0);
    push_box(1, 0, 0, 5, 0, 0);
    push_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    push_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
             32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    drain();
    set_primitive(SHAPE_SPHERE, 32'sh7fffffff, 32'sh80000000, 0,
                  32'h7fffffff, 0, 32'h7fffffff);
    push_box(32'sh80000000, 32'sh7fffffff, 0, 32'sh80000000, 32'sh7fffffff, 0);
    push_box(0, 0, 0, 0, 0, 0);
    drain();
    set_primitive(SHAPE_BOX, 0, 0, 0, 32'h20000, 32'h20000, 0);
    push_box(32'h10000, 32'h10000, 0, 32'h20000, 32'h20000, 0);
    push_box(32'h10001, 0, 0, 32'h20000, 0, 0);
    push_box(5, 5, 1, 3, 3, 2);
    drain();
    set_primitive(SHAPE_CYLINDER, 0, 0, 32'sh80000000, 32'h10000, 32'h7fffffff, 0);
    push_box(32'h10000, 0, 32'sh7ffffffe, 32'h20000, 0, 32'sh7fffffff);
    push_box(32'h10001, 0, 0, 32'h20000, 0, 0);
    drain();
    set_primitive(SHAPE_CONE, 0, 0, 0, 32'h10000, 32'h10000, 0);
    push_box(32'h8000, 0, 32'h8000, 32'h9000, 0, 32'h9000);
    push_box(32'h8001, 0, 32'h8000, 32'h9000, 0, 32'h9000);
    push_box(0, 0, 32'h10000, 0, 0, 32'h20000);
    push_box(0, 0, -5, 0, 0, -1);
    drain();
    set_primitive(SHAPE_CONE, 0, 0, 0, 32'h10000, 0, 0);
    push_box(0, 0, 0, 0, 0, 0);
    push_box(-1, -1, -1, 1, 1, 1);
    drain();

    // Random phases over all shapes, with a long receiver hold-off in one.
    for (phase = 0; phase < 16; phase++) begin
      int span;
      span = (phase % 3 == 0) ? 32'h40000 : ((phase % 3 == 1) ? 64 : 32'h4000000);
      set_primitive(2'(phase % 4), $urandom, $urandom, $urandom,
                    (phase == 5) ? 32'h7fffffff : $urandom_range(0, span),
                    (phase == 7) ? 0 : $urandom_range(0, span),
                    $urandom_range(0, span));
      if (phase == 3) hold_off = 300;
      repeat (105) begin
        if ($urandom_range(0, 9) == 0) push_raw_box();
        else push_near_box(span);
      end
      drain();
    end

    $display("covered %0d boxes over sphere, box, cylinder and cone settings", sent);
    $display("%0d results compared, %0d of them hits", checked, hits_seen);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
